// ===== hdl/gso_pkg.sv =====
package gso_pkg;

   localparam int DATA_W  = 32;
   localparam int VIDX_W  = 2;
   localparam int CIDX_W  = 3;
   localparam int DIM_W   = 4;
   localparam int CNT_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 4;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;
   localparam int DIV_NUM_W  = 96;
   localparam int DIV_DEN_W  = 64;
   localparam int DIV_CNT_W  = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_COUNT = 2'd1;

   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_COEF = 7'd96;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_NORM = 7'd47;

   typedef struct packed {
      logic                    start;
      logic [DIV_CNT_W-1:0]    steps;
      logic [DIV_NUM_W-1:0]    dividend;
      logic [DIV_DEN_W-1:0]    divisor;
   } gso_div_req_type;

   typedef struct packed {
      logic                    done;
      logic [DIV_DEN_W-1:0]    quotient;
   } gso_div_rsp_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/gso_ram.sv =====
module gso_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/gso_divider.sv =====
module gso_divider
   import gso_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  gso_div_req_type req,
   output gso_div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 sat_ff, sat_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] q_ff, q_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   reduced;
   logic                 qbit;

   always_comb begin
      shifted = {rem_ff, num_ff[DIV_NUM_W-1]};
      qbit    = (shifted >= {1'b0, den_ff});
      reduced = qbit ? (shifted - {1'b0, den_ff}) : shifted;
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (req.start) begin
         busy_in = 1'b1;
         sat_in  = 1'b0;
         cnt_in  = req.steps;
         num_in  = req.dividend;
         den_in  = req.divisor;
         rem_in  = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         rem_in = reduced[DIV_DEN_W-1:0];
         // freeze once the quotient would pass the signed 64-bit limit
         if (q_ff[DIV_DEN_W-2]) begin
            sat_in = 1'b1;
         end else begin
            q_in = {q_ff[DIV_DEN_W-2:0], qbit};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = sat_ff ? 64'h7FFF_FFFF_FFFF_FFFF : q_ff;

endmodule

// ===== hdl/gso_sqrt.sv =====
module gso_sqrt
   import gso_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [63:0]       radicand,
   output logic              done,
   output logic [DATA_W-1:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] trial;

   always_comb begin
      trial   = r_ff + b_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         x_in    = radicand;
         r_in    = '0;
         b_in    = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in   = b_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign root = r_ff[DATA_W-1:0];

endmodule

// ===== hdl/gram_schmidt_orthonormalizer_unit.sv =====
// Gram-Schmidt orthonormalizer.
// req_ channel: one signed Q16.16 component per item, vector-major order, until
// vector_count * dimension components are in. req_tready is high only while
// loading, so one item enters per cycle during the load.
// After the last component the block orthogonalizes the set in place in its
// vector store, then sends every orthogonal vector (tuser bit 0 low) and then
// every unit-normalized vector (tuser bit 0 high) on the rsp_ channel, one
// component per item; tlast marks the final item of the run.
// Each dot product runs through the single store read port; each projection
// adds a coefficient divide and a subtract/write-back pass over the vector;
// each normalized vector adds a square root and a divide per component.
// Emission reads each item from the store before it is sent. The shared
// bit-serial divider sets the pace of a run.
// csr_ channel: always ready; a write to dimension or vector_count drops any
// partial load. Reset clears the control state and restores dimension 8 and
// vector_count 4. When the receiver stalls, the output register holds the item
// and the sequencer waits.
module gram_schmidt_orthonormalizer_unit
   import gso_pkg::*;
#(
   parameter int MAX_DIM  = 8,
   parameter int MAX_VECS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // [31:0] component
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] value, [33:32] vector_index,
                                              // [36:34] component_index, [39:37] zero
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [0] normalized, [1] degenerate
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_data
);

   localparam int DEPTH  = MAX_VECS * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [4:0] S_LOAD     = 5'd0;
   localparam logic [4:0] S_PJ_START = 5'd1;
   localparam logic [4:0] S_DOT_RA   = 5'd2;
   localparam logic [4:0] S_DOT_RB   = 5'd3;
   localparam logic [4:0] S_DOT_MUL  = 5'd4;
   localparam logic [4:0] S_DOT_ACC  = 5'd5;
   localparam logic [4:0] S_PJ_DJJ   = 5'd6;
   localparam logic [4:0] S_PJ_DIV   = 5'd7;
   localparam logic [4:0] S_PJ_WDIV  = 5'd8;
   localparam logic [4:0] S_PR_RJ    = 5'd9;
   localparam logic [4:0] S_PR_MH    = 5'd10;
   localparam logic [4:0] S_PR_ML    = 5'd11;
   localparam logic [4:0] S_PR_SUM   = 5'd12;
   localparam logic [4:0] S_PR_WR    = 5'd13;
   localparam logic [4:0] S_PJ_NEXT  = 5'd14;
   localparam logic [4:0] S_OE_RD    = 5'd15;
   localparam logic [4:0] S_OE_OUT   = 5'd16;
   localparam logic [4:0] S_NM_START = 5'd17;
   localparam logic [4:0] S_NM_SQ    = 5'd18;
   localparam logic [4:0] S_NM_WSQ   = 5'd19;
   localparam logic [4:0] S_NM_RD    = 5'd20;
   localparam logic [4:0] S_NM_DIV   = 5'd21;
   localparam logic [4:0] S_NM_WDIV  = 5'd22;
   localparam logic [4:0] S_NM_OUT   = 5'd23;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [VIDX_W-1:0] v,
                                                 input logic [CIDX_W-1:0] c);
      return ADDR_W'(int'(v) * MAX_DIM + int'(c));
   endfunction

   // configuration
   logic [DIM_W-1:0]  dim_ff, dim_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIM_W-1:0]  d_eff;
   logic [CNT_W-1:0]  n_eff;
   logic [CIDX_W-1:0] d_last;
   logic [VIDX_W-1:0] n_last;

   // sequencer
   logic [4:0]        state_ff, state_in;
   logic [4:0]        ret_ff, ret_in;
   logic [VIDX_W-1:0] lv_ff, lv_in;
   logic [CIDX_W-1:0] lc_ff, lc_in;
   logic [VIDX_W-1:0] i_ff, i_in;
   logic [VIDX_W-1:0] j_ff, j_in;
   logic [CIDX_W-1:0] k_ff, k_in;
   logic [VIDX_W-1:0] da_ff, da_in;
   logic [VIDX_W-1:0] db_ff, db_in;
   logic [(2**VIDX_W)-1:0] marks_ff, marks_in;

   // datapath
   logic signed [63:0]       acc_ff, acc_in;
   logic signed [DATA_W-1:0] opa_ff, opa_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic [63:0]              djj_ff, djj_in;
   logic                     neg_ff, neg_in;
   logic signed [DATA_W-1:0] chi_ff, chi_in;
   logic [DATA_W-1:0]        clo_ff, clo_in;
   logic signed [DATA_W-1:0] vj_ff, vj_in;
   logic signed [DATA_W-1:0] vi_ff, vi_in;
   logic signed [63:0]       mhi_ff, mhi_in;
   logic signed [63:0]       mlo_ff, mlo_in;
   logic signed [DATA_W-1:0] proj_ff, proj_in;
   logic [DATA_W-1:0]        nr_ff, nr_in;
   logic signed [DATA_W-1:0] res_ff, res_in;

   // output register
   logic                  ov_ff, ov_in;
   logic [RSP_DATA_W-1:0] od_ff, od_in;
   logic [RSP_USER_W-1:0] ou_ff, ou_in;
   logic                  ol_ff, ol_in;
   logic                  out_free;

   // memory and units
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;
   logic signed [DATA_W-1:0] rd_s;
   gso_div_req_type   div_req;
   gso_div_rsp_type   div_rsp;
   logic              sq_start, sq_done;
   logic [63:0]       sq_radicand;
   logic [DATA_W-1:0] sq_root;

   logic signed [63:0] dot_prod, hi_prod;
   logic signed [64:0] lo_prod;
   logic signed [63:0] coef;
   logic signed [63:0] qs;
   logic [63:0]        acc_mag;
   logic [DATA_W-1:0]  v_mag;
   logic               req_fire, csr_fire;

   assign rd_s     = $signed(rd_data);
   assign dot_prod = opa_ff * rd_s;
   assign hi_prod  = chi_ff * rd_s;
   assign lo_prod  = $signed({1'b0, clo_ff}) * vj_ff;
   assign acc_mag  = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
   assign v_mag    = DATA_W'(32'd0 - rd_data);
   assign coef     = neg_ff ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
   assign qs       = neg_ff ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);

   assign d_eff  = (dim_ff == '0) ? DIM_W'(1) :
                   ((int'(dim_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_ff);
   assign n_eff  = (cnt_ff == '0) ? CNT_W'(1) :
                   ((int'(cnt_ff) > MAX_VECS) ? CNT_W'(MAX_VECS) : cnt_ff);
   assign d_last = CIDX_W'(d_eff - 1'b1);
   assign n_last = VIDX_W'(n_eff - 1'b1);

   assign req_tready = (state_ff == S_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_free   = !ov_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      dim_in   = dim_ff;
      cnt_in   = cnt_ff;
      lv_in    = lv_ff;
      lc_in    = lc_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      da_in    = da_ff;
      db_in    = db_ff;
      marks_in = marks_ff;
      acc_in   = acc_ff;
      opa_in   = opa_ff;
      prod_in  = prod_ff;
      djj_in   = djj_ff;
      neg_in   = neg_ff;
      chi_in   = chi_ff;
      clo_in   = clo_ff;
      vj_in    = vj_ff;
      vi_in    = vi_ff;
      mhi_in   = mhi_ff;
      mlo_in   = mlo_ff;
      proj_in  = proj_ff;
      nr_in    = nr_ff;
      res_in   = res_ff;
      ov_in    = ov_ff && !rsp_tready;
      od_in    = od_ff;
      ou_in    = ou_ff;
      ol_in    = ol_ff;
      wr_en    = 1'b0;
      wr_addr  = addr_of(lv_ff, lc_ff);
      wr_data  = req_tdata;
      rd_en    = 1'b0;
      rd_addr  = addr_of(i_ff, k_ff);
      div_req  = '{start: 1'b0, steps: DIV_STEPS_COEF,
                   dividend: {acc_mag, 32'd0}, divisor: djj_ff};
      sq_start = 1'b0;
      sq_radicand = {acc_ff[62:0], 1'b0};

      // register writes drop any partial load
      if (csr_fire) begin
         case (csr_index)
            CSR_DIMENSION: begin
               dim_in = csr_data;
               lv_in  = '0;
               lc_in  = '0;
            end
            CSR_VECTOR_COUNT: begin
               cnt_in = csr_data[CNT_W-1:0];
               lv_in  = '0;
               lc_in  = '0;
            end
            default: ;
         endcase
      end

      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               wr_en = 1'b1;
               if (lc_ff == d_last) begin
                  lc_in = '0;
                  if (lv_ff == n_last) begin
                     lv_in    = '0;
                     marks_in = '0;
                     i_in     = (n_last == '0) ? VIDX_W'(0) : VIDX_W'(1);
                     j_in     = '0;
                     k_in     = '0;
                     state_in = (n_last == '0) ? S_OE_RD : S_PJ_START;
                  end else begin
                     lv_in = lv_ff + 1'b1;
                  end
               end else begin
                  lc_in = lc_ff + 1'b1;
               end
            end
         end
         S_PJ_START: begin
            acc_in   = '0;
            da_in    = j_ff;
            db_in    = j_ff;
            ret_in   = S_PJ_DJJ;
            state_in = S_DOT_RA;
         end
         S_DOT_RA: begin
            rd_en    = 1'b1;
            rd_addr  = addr_of(da_ff, k_ff);
            state_in = S_DOT_RB;
         end
         S_DOT_RB: begin
            opa_in   = rd_s;
            rd_en    = 1'b1;
            rd_addr  = addr_of(db_ff, k_ff);
            state_in = S_DOT_MUL;
         end
         S_DOT_MUL: begin
            prod_in  = dot_prod;
            state_in = S_DOT_ACC;
         end
         S_DOT_ACC: begin
            acc_in = acc_ff + (prod_ff >>> 3);
            if (k_ff == d_last) begin
               k_in     = '0;
               state_in = ret_ff;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_DOT_RA;
            end
         end
         S_PJ_DJJ: begin
            // zero earlier vector: no projection, flag this vector
            if (acc_ff == '0) begin
               marks_in[i_ff] = 1'b1;
               state_in       = S_PJ_NEXT;
            end else begin
               djj_in   = acc_ff;
               acc_in   = '0;
               da_in    = j_ff;
               db_in    = i_ff;
               ret_in   = S_PJ_DIV;
               state_in = S_DOT_RA;
            end
         end
         S_PJ_DIV: begin
            div_req.start = 1'b1;
            neg_in        = acc_ff[63];
            state_in      = S_PJ_WDIV;
         end
         S_PJ_WDIV: begin
            if (div_rsp.done) begin
               chi_in   = coef[63:32];
               clo_in   = coef[31:0];
               k_in     = '0;
               state_in = S_PR_RJ;
            end
         end
         S_PR_RJ: begin
            rd_en    = 1'b1;
            rd_addr  = addr_of(j_ff, k_ff);
            state_in = S_PR_MH;
         end
         S_PR_MH: begin
            vj_in    = rd_s;
            mhi_in   = hi_prod;
            rd_en    = 1'b1;
            rd_addr  = addr_of(i_ff, k_ff);
            state_in = S_PR_ML;
         end
         S_PR_ML: begin
            vi_in    = rd_s;
            mlo_in   = lo_prod[63:0];
            state_in = S_PR_SUM;
         end
         S_PR_SUM: begin
            proj_in  = sat32(mhi_ff + (mlo_ff >>> 32));
            state_in = S_PR_WR;
         end
         S_PR_WR: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(i_ff, k_ff);
            wr_data = sat32(64'(vi_ff) - 64'(proj_ff));
            if (k_ff == d_last) begin
               k_in     = '0;
               state_in = S_PJ_NEXT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_PR_RJ;
            end
         end
         S_PJ_NEXT: begin
            if (j_ff == i_ff - 1'b1) begin
               j_in = '0;
               if (i_ff == n_last) begin
                  i_in     = '0;
                  state_in = S_OE_RD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_PJ_START;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_PJ_START;
            end
         end
         S_OE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = addr_of(i_ff, k_ff);
            state_in = S_OE_OUT;
         end
         S_OE_OUT: begin
            if (out_free) begin
               ov_in = 1'b1;
               od_in = {3'b000, k_ff, i_ff, rd_data};
               ou_in = {marks_ff[i_ff], 1'b0};
               ol_in = 1'b0;
               if (k_ff == d_last) begin
                  k_in = '0;
                  if (i_ff == n_last) begin
                     i_in     = '0;
                     state_in = S_NM_START;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_OE_RD;
                  end
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_OE_RD;
               end
            end
         end
         S_NM_START: begin
            acc_in   = '0;
            da_in    = i_ff;
            db_in    = i_ff;
            ret_in   = S_NM_SQ;
            state_in = S_DOT_RA;
         end
         S_NM_SQ: begin
            sq_start = 1'b1;
            state_in = S_NM_WSQ;
         end
         S_NM_WSQ: begin
            if (sq_done) begin
               nr_in = sq_root;
               if (sq_root == '0) begin
                  marks_in[i_ff] = 1'b1;
               end
               state_in = S_NM_RD;
            end
         end
         S_NM_RD: begin
            rd_en    = 1'b1;
            rd_addr  = addr_of(i_ff, k_ff);
            state_in = S_NM_DIV;
         end
         S_NM_DIV: begin
            if (nr_ff == '0) begin
               res_in   = '0;
               state_in = S_NM_OUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.steps    = DIV_STEPS_NORM;
               div_req.dividend = {(rd_s[DATA_W-1] ? v_mag : rd_data), 64'd0};
               div_req.divisor  = {32'd0, nr_ff};
               neg_in           = rd_s[DATA_W-1];
               state_in         = S_NM_WDIV;
            end
         end
         S_NM_WDIV: begin
            if (div_rsp.done) begin
               res_in   = sat32(qs);
               state_in = S_NM_OUT;
            end
         end
         S_NM_OUT: begin
            if (out_free) begin
               ov_in = 1'b1;
               od_in = {3'b000, k_ff, i_ff, res_ff};
               ou_in = {marks_ff[i_ff], 1'b1};
               ol_in = (k_ff == d_last) && (i_ff == n_last);
               if (k_ff == d_last) begin
                  k_in = '0;
                  if (i_ff == n_last) begin
                     i_in     = '0;
                     state_in = S_LOAD;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_NM_START;
                  end
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_NM_RD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         ret_ff   <= S_LOAD;
         dim_ff   <= DIM_W'(8);
         cnt_ff   <= CNT_W'(4);
         lv_ff    <= '0;
         lc_ff    <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         da_ff    <= '0;
         db_ff    <= '0;
         marks_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         dim_ff   <= dim_in;
         cnt_ff   <= cnt_in;
         lv_ff    <= lv_in;
         lc_ff    <= lc_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         da_ff    <= da_in;
         db_ff    <= db_in;
         marks_ff <= marks_in;
         ov_ff    <= ov_in;
      end
      acc_ff  <= acc_in;
      opa_ff  <= opa_in;
      prod_ff <= prod_in;
      djj_ff  <= djj_in;
      neg_ff  <= neg_in;
      chi_ff  <= chi_in;
      clo_ff  <= clo_in;
      vj_ff   <= vj_in;
      vi_ff   <= vi_in;
      mhi_ff  <= mhi_in;
      mlo_ff  <= mlo_in;
      proj_ff <= proj_in;
      nr_ff   <= nr_in;
      res_ff  <= res_in;
      od_ff   <= od_in;
      ou_ff   <= ou_in;
      ol_ff   <= ol_in;
   end

   gso_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gso_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gso_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_radicand),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ou_ff;
   assign rsp_tlast  = ol_ff;

endmodule

// ===== hdl/gso_checker.sv =====
module gso_checker
   import gso_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp item changed");

   // no output straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // no new load while an item before the last of a run is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken during emission");

   // the final item of a run belongs to the normalized pass
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("last item not normalized");

endmodule

bind gram_schmidt_orthonormalizer_unit gso_checker u_gso_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
